[design/cenc_pkg.sv]
// ----------------------------------------------------------------------------
// cenc_pkg: shared types and constants
// Widths, reset values and encoder cell tap masks for the K=7 rate-1/2
// convolutional encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cenc_pkg;

   localparam int FFT_SIZE_DEFAULT    = 64;
   localparam int PILOT_SPACING_RESET = 4;

   localparam int BYTE_W   = 8;
   localparam int NIBBLE_W = 4;
   localparam int STATE_W  = 6;
   localparam int CNT_W    = 13;
   localparam int PAIR_W   = 2;
   localparam int CELL_COUNT = STATE_W / PAIR_W;
   localparam int PAIR_IDX_W = 2;

   typedef logic [CNT_W-1:0]    count_type;
   typedef logic [NIBBLE_W-1:0] nibble_type;
   typedef logic [PAIR_W-1:0]   pair_type;
   typedef logic [2*NIBBLE_W-1:0] tap_mask_type;

   typedef enum logic {
      KIND_SYMBOL = 1'b0,
      KIND_STATE  = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic      busy;
      count_type frame_len;
   } frame_len_status_type;

   // Two mask bits per nibble bit: {state bit 2k+1, state bit 2k} of cell k.
   localparam tap_mask_type CELL_TAPS [CELL_COUNT] = '{
      8'b1111_1110,
      8'b0010_0101,
      8'b0101_1011
   };

endpackage

`default_nettype wire

[design/cenc_cell.sv]
// ----------------------------------------------------------------------------
// cenc_cell: encoder shift cell
// Holds two bits of the encoder shift register, passes them to the next cell
// on each shift and folds its taps into the running parity of the nibble.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cenc_cell #(
   parameter cenc_pkg::tap_mask_type TAP_MASK = '0
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   shift_en,
   input  wire cenc_pkg::pair_type   pair_in,
   output cenc_pkg::pair_type        pair_out,
   input  wire cenc_pkg::nibble_type par_in,
   output cenc_pkg::nibble_type      par_out
);
   import cenc_pkg::*;

   pair_type pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= '0;
      end else if (shift_en) begin
         pair_ff <= pair_in;
      end
   end

   always_comb begin
      for (int n = 0; n < NIBBLE_W; n++) begin
         par_out[n] = par_in[n] ^ (^(TAP_MASK[2*n +: 2] & pair_ff));
      end
   end

   assign pair_out = pair_ff;

endmodule

`default_nettype wire

[design/cenc_frame_len.sv]
// ----------------------------------------------------------------------------
// cenc_frame_len: frame length unit
// Holds the frame length FFT_SIZE - FFT_SIZE/spacing (FFT_SIZE at spacing 0);
// register writes redo it via restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cenc_frame_len #(
   parameter int FFT_SIZE = cenc_pkg::FFT_SIZE_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire cenc_pkg::count_type          spacing,
   output cenc_pkg::frame_len_status_type    status
);
   import cenc_pkg::*;

   localparam int QW = $clog2(FFT_SIZE + 1);
   localparam int IW = $clog2(QW + 1);
   localparam count_type FULL_LEN  = CNT_W'(FFT_SIZE);
   localparam count_type RESET_LEN = CNT_W'(FFT_SIZE - FFT_SIZE / PILOT_SPACING_RESET);

   logic              busy_ff;
   count_type         divisor_ff;
   count_type         rem_ff;
   logic [QW-1:0]     quo_ff;
   logic [IW-1:0]     iter_ff;
   count_type         frame_len_ff;

   logic [CNT_W:0]    rem_shift;
   logic [CNT_W:0]    rem_diff;
   logic              fits;
   count_type         rem_in;
   logic [QW-1:0]     quo_in;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[QW-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = (rem_shift >= {1'b0, divisor_ff});
      rem_in    = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      quo_in    = {quo_ff[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         frame_len_ff <= RESET_LEN;
      end else if (busy_ff) begin
         if (iter_ff == IW'(1)) begin
            busy_ff      <= 1'b0;
            frame_len_ff <= FULL_LEN - CNT_W'(quo_in);
         end
      end else if (start) begin
         if (spacing == '0) begin
            frame_len_ff <= FULL_LEN;
         end else begin
            busy_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         iter_ff <= iter_ff - IW'(1);
      end else if (start) begin
         divisor_ff <= spacing;
         rem_ff     <= '0;
         quo_ff     <= QW'(FFT_SIZE);
         iter_ff    <= IW'(QW);
      end
   end

   assign status.busy      = busy_ff;
   assign status.frame_len = frame_len_ff;

endmodule

`default_nettype wire

[design/conv_encoder_k7_rate_half_top.sv]
// ----------------------------------------------------------------------------
// conv_encoder_k7_rate_half_top: K=7 rate-1/2 convolutional encoder
// Encodes data bytes with generators 133/171 into coded nibbles that fill
// frames of FFT_SIZE - FFT_SIZE/pilot_spacing symbols, with a state report
// at each frame end.
//
// Use: an item on req_ carries one data byte. The byte is coded two bits per
// nibble, low bits first; each nibble leaves on rsp_ as one item with
// rsp_result_kind 0. When a frame fills, the rest of the byte is dropped and
// an item with rsp_result_kind 1 carries the 6-bit encoder state. rsp_last
// marks the final item caused by a byte.
// Timing: a taken byte is held in the byte register, and each item it
// causes is registered on rsp_. The three-cell shift chain codes one nibble
// per cycle while rsp_ready does not stall it; a byte gives one item per
// coded nibble, plus a state report when it closes a frame, and the next byte
// is taken in the cycle its predecessor's last item is produced. A csr_ write
// with nonzero spacing starts a bit-serial divide; req_ready and csr_ready
// are low meanwhile. A new length applies from the next frame start.
// Reset: encoder state and symbol count clear, pilot spacing returns to 4.
// A stalled rsp_ready holds the output item and stops coding; one byte is
// buffered inside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module conv_encoder_k7_rate_half_top #(
   parameter int FFT_SIZE = cenc_pkg::FFT_SIZE_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire [cenc_pkg::CNT_W-1:0]    csr_pilot_spacing,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire [cenc_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic                     rsp_result_kind,
   output logic [cenc_pkg::NIBBLE_W-1:0] rsp_coded_bits,
   output logic [cenc_pkg::STATE_W-1:0]  rsp_final_state,
   output logic                     rsp_last
);
   import cenc_pkg::*;

   frame_len_status_type len_status;

   logic                  work_valid_ff;
   logic [BYTE_W-1:0]     byte_ff;
   logic [PAIR_IDX_W-1:0] pair_ff;
   logic                  report_ff;
   count_type             count_ff;
   count_type             frame_symbols_ff;

   logic                  rsp_valid_ff;
   result_kind_type       rsp_kind_ff;
   nibble_type            rsp_bits_ff;
   logic [STATE_W-1:0]    rsp_state_ff;
   logic                  rsp_last_ff;

   logic                  out_free;
   logic                  step;
   logic                  first_step;
   count_type             eff_frame;
   logic                  is_report;
   count_type             count_next;
   logic                  step_done;
   logic                  go_report;
   logic                  req_take;
   pair_type              in_bits;
   pair_type              chain_pair [CELL_COUNT+1];
   nibble_type            chain_par  [CELL_COUNT+1];
   logic [STATE_W-1:0]    enc_state;

   cenc_frame_len #(
      .FFT_SIZE (FFT_SIZE)
   ) u_frame_len (
      .clock   (clock),
      .reset   (reset),
      .start   (csr_valid && csr_ready),
      .spacing (csr_pilot_spacing),
      .status  (len_status)
   );

   assign csr_ready = !len_status.busy;

   always_comb begin
      in_bits       = byte_ff[{pair_ff, 1'b0} +: PAIR_W];
      chain_pair[0] = {in_bits[0], in_bits[1]};
      chain_par[0]  = {in_bits[1] ^ in_bits[0], in_bits[1], in_bits[0], in_bits[0]};
   end

   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      cenc_cell #(
         .TAP_MASK (CELL_TAPS[k])
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (step && !is_report),
         .pair_in  (chain_pair[k]),
         .pair_out (chain_pair[k+1]),
         .par_in   (chain_par[k]),
         .par_out  (chain_par[k+1])
      );
      assign enc_state[PAIR_W*k +: PAIR_W] = chain_pair[k+1];
   end

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      step       = work_valid_ff && out_free;
      first_step = !report_ff && (pair_ff == '0) && (count_ff == '0);
      eff_frame  = first_step ? len_status.frame_len : frame_symbols_ff;
      is_report  = report_ff || (count_ff >= eff_frame);
      count_next = count_ff + CNT_W'(1);
      go_report  = !is_report && (count_next >= eff_frame);
      step_done  = is_report || (!go_report && (pair_ff == PAIR_IDX_W'(3)));
      req_take   = !len_status.busy && (!work_valid_ff || (step && step_done));
   end

   assign req_ready = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff    <= 1'b0;
         count_ff         <= '0;
         frame_symbols_ff <= '0;
      end else begin
         if (req_valid && req_take) begin
            work_valid_ff <= 1'b1;
         end else if (step && step_done) begin
            work_valid_ff <= 1'b0;
         end
         if (step) begin
            if (first_step) begin
               frame_symbols_ff <= len_status.frame_len;
            end
            count_ff <= is_report ? '0 : count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_take) begin
         byte_ff   <= req_data_byte;
         pair_ff   <= '0;
         report_ff <= 1'b0;
      end else if (step && !is_report) begin
         pair_ff   <= pair_ff + PAIR_IDX_W'(1);
         report_ff <= go_report;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_kind_ff  <= is_report ? KIND_STATE : KIND_SYMBOL;
         rsp_bits_ff  <= is_report ? '0 : chain_par[CELL_COUNT];
         rsp_state_ff <= is_report ? enc_state : '0;
         rsp_last_ff  <= step_done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_coded_bits  = rsp_bits_ff;
   assign rsp_final_state = rsp_state_ff;
   assign rsp_last        = rsp_last_ff;

   a_report_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_STATE) |-> rsp_last)
      else $error("state report not marked last");

   a_count_in_frame : assert property (@(posedge clock) disable iff (reset)
      count_ff <= frame_symbols_ff || count_ff == '0)
      else $error("symbol count beyond frame length");

   a_no_take_while_dividing : assert property (@(posedge clock) disable iff (reset)
      len_status.busy |-> !req_ready)
      else $error("byte taken during frame length update");

   a_symbol_counts : assert property (@(posedge clock) disable iff (reset)
      step && !is_report |=> count_ff == $past(count_next))
      else $error("symbol count did not advance");

endmodule

`default_nettype wire
